// ===== rtl/gbp_pkg.sv =====
// Shared types and constants for the gshare branch predictor.
package gbp_pkg;

    localparam int ADDR_W      = 64;
    localparam int TOTAL_W     = 32;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;

    localparam logic       CMD_PREDICT    = 1'b0;
    localparam logic       CMD_UPDATE     = 1'b1;
    localparam logic       MODE_TAKEN     = 1'b0;
    localparam logic       MODE_GSHARE    = 1'b1;
    localparam logic [1:0] CTR_WEAK_TAKEN = 2'd2;
    localparam logic [1:0] CTR_MAX        = 2'd3;
    localparam logic [1:0] CTR_MIN        = 2'd0;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_status;

endpackage

// ===== rtl/gbp_ctrl.sv =====
// Controller: clearing pass, word acceptance and result hand-off.
module gbp_ctrl
    import gbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
            end
            ST_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            ST_EXEC: begin
                // hold the item until the output register can take its word
                o_cmd.commit = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

// ===== rtl/gbp_dp.sv =====
// Datapath: pattern table, global history, statistics and result register.
module gbp_dp
    import gbp_pkg::*;
#(
    parameter int HISTORY_BITS = 12,
    parameter int STAT_BITS    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    output t_dp_status        o_status,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              i_command,
    input  logic [ADDR_W-1:0] i_branch_address,
    input  logic              i_predicted_taken,
    input  logic              i_actual_taken,
    output logic              o_prediction,
    output logic [TOTAL_W-1:0] o_branch_total,
    output logic [TOTAL_W-1:0] o_mispredict_total
);

    localparam int TABLE_DEPTH = 1 << HISTORY_BITS;

    logic [1:0]              mem_table [TABLE_DEPTH];
    logic [1:0]              r_rd_data;
    logic [HISTORY_BITS-1:0] r_clr_idx;
    logic [HISTORY_BITS-1:0] r_history;
    logic [HISTORY_BITS-1:0] r_idx;
    logic                    r_cmd;
    logic                    r_pred_in;
    logic                    r_actual;
    logic                    r_policy_mode;
    logic [STAT_BITS-1:0]    r_branch_cnt;
    logic [STAT_BITS-1:0]    r_misp_cnt;
    logic                    r_out_pred;

    logic [HISTORY_BITS-1:0] rd_idx;
    logic [1:0]              n_ctr;
    logic                    n_pred;
    logic                    train;
    logic                    mem_we;
    logic [HISTORY_BITS-1:0] mem_waddr;
    logic [1:0]              mem_wdata;

    assign rd_idx = i_branch_address[HISTORY_BITS-1:0] ^ r_history;
    assign train  = (r_cmd == CMD_UPDATE) && (r_policy_mode == MODE_GSHARE);

    always_comb begin
        n_ctr = r_rd_data;
        if (r_actual) begin
            if (r_rd_data != CTR_MAX) begin
                n_ctr = r_rd_data + 2'd1;
            end
        end else if (r_rd_data != CTR_MIN) begin
            n_ctr = r_rd_data - 2'd1;
        end
    end

    always_comb begin
        if (r_cmd == CMD_UPDATE) begin
            n_pred = 1'b0;
        end else if (r_policy_mode == MODE_TAKEN) begin
            n_pred = 1'b1;
        end else begin
            n_pred = r_rd_data[1];
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = n_ctr;
        if (i_cmd.clear_wr) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_idx;
            mem_wdata = CTR_WEAK_TAKEN;
        end else if (i_cmd.commit && train) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_table[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_data <= mem_table[rd_idx];
        end
    end

    // latch the accepted word; load the output prediction on commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx     <= rd_idx;
            r_cmd     <= i_command;
            r_pred_in <= i_predicted_taken;
            r_actual  <= i_actual_taken;
        end
        if (i_cmd.commit) begin
            r_out_pred <= n_pred;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx     <= '0;
            r_history     <= '0;
            r_policy_mode <= MODE_GSHARE;
            r_branch_cnt  <= '0;
            r_misp_cnt    <= '0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr_idx <= r_clr_idx + HISTORY_BITS'(1);
            end
            if (i_cfg_wr_en) begin
                r_policy_mode <= i_cfg_wr_data;
            end
            if (i_cmd.commit && (r_cmd == CMD_UPDATE)) begin
                // saturate at all ones
                if (r_branch_cnt != '1) begin
                    r_branch_cnt <= r_branch_cnt + STAT_BITS'(1);
                end
                if ((r_pred_in != r_actual) && (r_misp_cnt != '1)) begin
                    r_misp_cnt <= r_misp_cnt + STAT_BITS'(1);
                end
                if (r_policy_mode == MODE_GSHARE) begin
                    r_history <= {r_history[HISTORY_BITS-2:0], r_actual};
                end
            end
        end
    end

    assign o_status.clear_last = (r_clr_idx == '1);

    // statistics change only on commit, when the output word is reloaded
    assign o_prediction       = r_out_pred;
    assign o_branch_total     = TOTAL_W'(r_branch_cnt);
    assign o_mispredict_total = TOTAL_W'(r_misp_cnt);

endmodule

// ===== rtl/gshare_branch_predictor.sv =====
// Top level of the gshare branch predictor: controller, datapath and stream ports.
//
//  channel   | direction | accepted when                  | contents
//  s_axis    | in        | s_axis_tvalid & s_axis_tready  | command, branch word
//  m_axis    | out       | m_axis_tvalid & m_axis_tready  | prediction, statistics
//  cfg       | in        | i_cfg_wr_en                    | policy_mode
//
// A word reads the pattern table on acceptance (registered read port); on commit
// an update word changes the statistics and, in gshare mode, counter and history.
// After reset a clearing pass writes all 2^HISTORY_BITS table entries (4096 at
// the default), with s_axis_tready low.
// A finished result waits in the output register; the next word is accepted
// meanwhile and finishes once that register is free.
module gshare_branch_predictor
    import gbp_pkg::*;
#(
    parameter int HISTORY_BITS = 12,
    parameter int STAT_BITS    = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [63:0] branch_address, [64] predicted_taken, [65] actual_taken, rest zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] command
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] prediction, [32:1] branch_total, [64:33] mispredict_total, rest zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_ctrl_cmd          cmd;
    t_dp_status         status;
    logic               prediction;
    logic [TOTAL_W-1:0] branch_total;
    logic [TOTAL_W-1:0] mispredict_total;

    gbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gbp_dp #(
        .HISTORY_BITS (HISTORY_BITS),
        .STAT_BITS    (STAT_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_command          (s_axis_tuser),
        .i_branch_address   (s_axis_tdata[ADDR_W-1:0]),
        .i_predicted_taken  (s_axis_tdata[ADDR_W]),
        .i_actual_taken     (s_axis_tdata[ADDR_W+1]),
        .o_prediction       (prediction),
        .o_branch_total     (branch_total),
        .o_mispredict_total (mispredict_total)
    );

    assign m_axis_tdata = {
        (OUT_TDATA_W - 2*TOTAL_W - 1)'(0),
        mispredict_total,
        branch_total,
        prediction
    };

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clear_wr, cmd.accept, cmd.commit}))
        else $error("controller issued more than one command");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("word accepted while another is in flight");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> m_axis_tvalid)
        else $error("committed result not presented");

    a_commit_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !$past(cmd.clear_wr))
        else $error("commit directly after clearing pass");

endmodule

// ===== tb/gshare_branch_predictor_tb.sv =====
// Self-checking testbench for the gshare branch predictor, with a cycle-free behavioral predictor.
module gshare_branch_predictor_tb;
    import gbp_pkg::*;

    localparam int HIST_W  = 12;
    localparam int TABLE_N = 1 << HIST_W;
    localparam int POOL_N  = 8;

    typedef struct packed {
        logic               taken;
        logic [TOTAL_W-1:0] branch_total;
        logic [TOTAL_W-1:0] mispredict_total;
    } t_branch_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic                   i_cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [63:0] branch_address, [64] predicted_taken, [65] actual_taken, rest zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // [0] command
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    // [0] prediction, [32:1] branch_total, [64:33] mispredict_total, rest zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Behavioral copy of the predictor state
    logic [1:0]         ctr_table [0:TABLE_N-1];
    logic [HIST_W-1:0]  ghist;
    logic [TOTAL_W-1:0] branch_cnt;
    logic [TOTAL_W-1:0] mispred_cnt;
    logic               policy_q;

    t_branch_result pending_results [$];
    int             error_count = 0;
    int             send_idle_pct;
    int             recv_stall_pct;

    gshare_branch_predictor #(
        .HISTORY_BITS (HIST_W),
        .STAT_BITS    (TOTAL_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [HIST_W-1:0] entry_of(input logic [ADDR_W-1:0] addr);
        return addr[HIST_W-1:0] ^ ghist;
    endfunction

    function automatic logic peek_direction(input logic [ADDR_W-1:0] addr);
        if (policy_q == MODE_TAKEN) begin
            return 1'b1;
        end
        return ctr_table[entry_of(addr)][1];
    endfunction

    // Address with random upper bits that lands on the given table entry right now
    function automatic logic [ADDR_W-1:0] addr_for_entry(input logic [HIST_W-1:0] entry);
        logic [ADDR_W-1:0] addr;
        addr = {$urandom, $urandom};
        addr[HIST_W-1:0] = entry ^ ghist;
        return addr;
    endfunction

    function automatic t_branch_result resolve_branch(input logic cmd,
                                                      input logic [ADDR_W-1:0] addr,
                                                      input logic pred,
                                                      input logic act);
        t_branch_result r;
        logic [HIST_W-1:0] idx;
        r.taken = 1'b0;
        if (cmd == CMD_PREDICT) begin
            r.taken = peek_direction(addr);
        end else begin
            if (branch_cnt != '1) begin
                branch_cnt = branch_cnt + 1'b1;
            end
            if (pred != act && mispred_cnt != '1) begin
                mispred_cnt = mispred_cnt + 1'b1;
            end
            if (policy_q == MODE_GSHARE) begin
                idx = entry_of(addr);
                if (act) begin
                    if (ctr_table[idx] != CTR_MAX) begin
                        ctr_table[idx] = ctr_table[idx] + 2'd1;
                    end
                end else if (ctr_table[idx] != CTR_MIN) begin
                    ctr_table[idx] = ctr_table[idx] - 2'd1;
                end
                ghist = {ghist[HIST_W-2:0], act};
            end
        end
        r.branch_total     = branch_cnt;
        r.mispredict_total = mispred_cnt;
        return r;
    endfunction

    // Called just after a falling edge; returns just after a falling edge with tvalid held
    task automatic send_word(input logic cmd, input logic [ADDR_W-1:0] addr,
                             input logic pred, input logic act);
        logic accepted;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = IN_TDATA_W'({$urandom, $urandom, $urandom});
            s_axis_tuser  = 1'($urandom);
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {6'b0, act, pred, addr};
        accepted = 1'b0;
        while (!accepted) begin
            @(posedge i_clk);
            accepted = s_axis_tready;
        end
        pending_results.push_back(resolve_branch(cmd, addr, pred, act));
        @(negedge i_clk);
    endtask

    task automatic drain;
        s_axis_tvalid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_policy(input logic mode);
        drain();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = mode;
        policy_q      = mode;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
    endtask

    // Fresh table answers weakly taken at both ends of the address range
    task automatic test_reset_state;
        send_word(CMD_PREDICT, '0, 1'b0, 1'b0);
        send_word(CMD_PREDICT, '1, 1'b1, 1'b1);
    endtask

    // Drive one entry to both saturation limits, covering every hint/outcome pair
    task automatic test_counter_saturation;
        logic [HIST_W-1:0] entry;
        entry = 12'h5a5;
        send_word(CMD_UPDATE, addr_for_entry(entry), 1'b1, 1'b0);
        send_word(CMD_UPDATE, addr_for_entry(entry), 1'b0, 1'b0);
        send_word(CMD_UPDATE, addr_for_entry(entry), 1'b0, 1'b0);
        send_word(CMD_PREDICT, addr_for_entry(entry), 1'b0, 1'b0);
        send_word(CMD_UPDATE, addr_for_entry(entry), 1'b0, 1'b1);
        send_word(CMD_UPDATE, addr_for_entry(entry), 1'b1, 1'b1);
        send_word(CMD_UPDATE, addr_for_entry(entry), 1'b1, 1'b1);
        send_word(CMD_UPDATE, {52'hfffffffffffff, entry ^ ghist}, 1'b1, 1'b1);
        send_word(CMD_PREDICT, addr_for_entry(entry), 1'b1, 1'b1);
    endtask

    // Taken mode answers taken over a not-taken entry and leaves table and history alone
    task automatic test_always_taken_mode;
        logic [HIST_W-1:0] entry;
        entry = 12'h0c3;
        send_word(CMD_UPDATE, addr_for_entry(entry), 1'b1, 1'b0);
        send_word(CMD_UPDATE, addr_for_entry(entry), 1'b1, 1'b0);
        write_policy(MODE_TAKEN);
        send_word(CMD_PREDICT, addr_for_entry(entry), 1'b0, 1'b0);
        send_word(CMD_UPDATE, addr_for_entry(entry), 1'b1, 1'b0);
        send_word(CMD_UPDATE, addr_for_entry(entry), 1'b0, 1'b1);
        write_policy(MODE_GSHARE);
        send_word(CMD_PREDICT, addr_for_entry(entry), 1'b0, 1'b0);
    endtask

    // Mostly predict/resolve pairs on a few biased hot branches, plus loose words
    task automatic test_random_traffic(input int n_words, input int idle_pct,
                                       input int stall_pct, input logic mode);
        logic [ADDR_W-1:0] hot_addr [POOL_N];
        int                hot_bias [POOL_N];
        logic [ADDR_W-1:0] addr;
        logic              guess;
        int                sent;
        int                pick;
        int                kind;
        write_policy(mode);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < POOL_N; i++) begin
            hot_addr[i] = {$urandom, $urandom};
            hot_bias[i] = (i % 4 == 0) ? 0 : (i % 4 == 1) ? 100 : $urandom_range(100);
        end
        sent = 0;
        while (sent < n_words) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                pick = $urandom_range(POOL_N - 1);
                addr = ($urandom_range(3) == 0) ? {$urandom, $urandom} : hot_addr[pick];
                guess = peek_direction(addr);
                send_word(CMD_PREDICT, addr, 1'($urandom), 1'($urandom));
                if ($urandom_range(9) == 0) begin
                    guess = 1'($urandom);
                end
                send_word(CMD_UPDATE, addr, guess, $urandom_range(99) < hot_bias[pick]);
                sent += 2;
            end else if (kind < 85) begin
                send_word(CMD_UPDATE, {$urandom, $urandom}, 1'($urandom), 1'($urandom));
                sent++;
            end else begin
                send_word(CMD_PREDICT, {$urandom, $urandom}, 1'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_branch_result got;
        t_branch_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.taken            = m_axis_tdata[0];
            got.branch_total     = m_axis_tdata[32:1];
            got.mispredict_total = m_axis_tdata[64:33];
            if (pending_results.size() == 0) begin
                $error("unexpected result word: prediction %0b branch_total %0d",
                       got.taken, got.branch_total);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.taken !== want.taken) begin
                    $error("prediction: expected %0b, got %0b", want.taken, got.taken);
                    error_count++;
                end
                if (got.branch_total !== want.branch_total) begin
                    $error("branch_total: expected %0d, got %0d",
                           want.branch_total, got.branch_total);
                    error_count++;
                end
                if (got.mispredict_total !== want.mispredict_total) begin
                    $error("mispredict_total: expected %0d, got %0d",
                           want.mispredict_total, got.mispredict_total);
                    error_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        send_idle_pct  = 19;
        recv_stall_pct = 58;
        for (int i = 0; i < TABLE_N; i++) begin
            ctr_table[i] = CTR_WEAK_TAKEN;
        end
        ghist       = '0;
        branch_cnt  = '0;
        mispred_cnt = '0;
        policy_q    = MODE_GSHARE;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_counter_saturation();
        test_always_taken_mode();
        test_random_traffic(550, 19, 58, MODE_GSHARE);
        test_random_traffic(550, 58, 19, MODE_TAKEN);
        test_random_traffic(550, 0, 0, MODE_GSHARE);
        drain();
        repeat (8) @(negedge i_clk);

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== gshare_branch_predictor.f =====
rtl/gbp_pkg.sv
rtl/gbp_ctrl.sv
rtl/gbp_dp.sv
rtl/gshare_branch_predictor.sv
tb/gshare_branch_predictor_tb.sv
